[hw/rtl/hms_clock_with_button_setting_macros.svh]
// Assertion macros for the clock RTL, included by the core file.
`ifndef HMS_CLOCK_WITH_BUTTON_SETTING_MACROS_SVH
`define HMS_CLOCK_WITH_BUTTON_SETTING_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define HMS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define HMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HMS_ASSERT_SAME(label, ante, cons, msg)
`define HMS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[hw/rtl/hms_pkg.sv]
// Shared types and constants for the hours:minutes:seconds clock.
package hms_pkg;

    localparam int BTN_MIN  = 0;
    localparam int BTN_SEC  = 1;
    localparam int BTN_DOWN = 2;
    localparam int BTN_HOUR = 3;
    localparam int BTN_UP   = 4;

    localparam logic [6:0] TICK_DIVIDE_RST    = 7'd99;
    localparam logic [3:0] DEBOUNCE_TICKS_RST = 4'd3;
    localparam logic [6:0] REPEAT_DELAY_RST   = 7'd99;
    localparam logic [6:0] REPEAT_PERIOD_RST  = 7'd49;

    typedef enum logic [1:0] {
        CFG_TICK_DIVIDE    = 2'd0,
        CFG_DEBOUNCE_TICKS = 2'd1,
        CFG_REPEAT_DELAY   = 2'd2,
        CFG_REPEAT_PERIOD  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [6:0] tick_divide;
        logic [3:0] debounce_ticks;
        logic [6:0] repeat_delay;
        logic [6:0] repeat_period;
    } cfg_t;

    typedef struct packed {
        logic       func;
        logic [4:0] buttons;
    } item_t;

    typedef struct packed {
        logic [4:0] hour_now;
        logic [5:0] minute_now;
        logic [5:0] second_now;
        logic       time_updated;
    } result_t;

endpackage

[hw/rtl/hms_in_stage.sv]
// Input register stage: holds one accepted item until the core takes it.
module hms_in_stage
    import hms_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  item_t s_item,
    input  logic  take,
    output logic  valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_tready = !valid_reg || take;
    assign valid    = valid_reg;
    assign item     = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_item;
        end
    end

endmodule

[hw/rtl/hms_core.sv]
// Clock state and the next-state logic for one tick or button item.
module hms_core
    import hms_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

`include "hms_clock_with_button_setting_macros.svh"

    localparam logic [6:0] HOURS   = 7'd24;
    localparam logic [6:0] MINUTES = 7'd60;

    logic [6:0] prescale_reg, prescale_next;
    logic [3:0] deb_reg, deb_next;
    logic [6:0] rep_reg, rep_next;
    logic [4:0] held_reg, held_next;
    logic       pa_reg, pa_next;
    logic [4:0] hour_reg, hour_next;
    logic [5:0] minute_reg, minute_next;
    logic [5:0] second_reg, second_next;

    logic [6:0] pre_inc;
    logic       wrap;
    logic       any_held;
    logic       rep_fire;
    logic       deb_fire;
    logic       do_apply;
    logic       updated;

    function automatic logic [6:0] inc_wrap(logic [6:0] v, logic [6:0] modulus);
        logic [6:0] v1;
        v1 = v + 7'd1;
        return (v1 >= modulus) ? 7'd0 : v1;
    endfunction

    function automatic logic [6:0] dec_wrap(logic [6:0] v, logic [6:0] modulus);
        return (v == 7'd0 || v >= modulus) ? (modulus - 7'd1) : (v - 7'd1);
    endfunction

    always_comb
    begin
        prescale_next = prescale_reg;
        deb_next      = deb_reg;
        rep_next      = rep_reg;
        held_next     = held_reg;
        pa_next       = pa_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        second_next   = second_reg;
        updated       = 1'b0;
        pre_inc       = prescale_reg + 7'd1;
        wrap          = pre_inc >= cfg.tick_divide;
        any_held      = |held_reg;
        rep_fire      = (rep_reg == 7'd1) && any_held;
        deb_fire      = (deb_reg == 4'd1);
        do_apply      = any_held && (rep_fire || (deb_fire && !pa_reg));

        if (item.func)
        begin
            held_next = item.buttons;
            deb_next  = cfg.debounce_ticks;
            rep_next  = cfg.repeat_delay;
        end
        else
        begin
            prescale_next = wrap ? 7'd0 : pre_inc;

            // advance only with no button held, apply only with one held
            if (wrap && !any_held)
            begin
                second_next = 6'(inc_wrap({1'b0, second_reg}, MINUTES));
                if (second_next == 6'd0)
                begin
                    minute_next = 6'(inc_wrap({1'b0, minute_reg}, MINUTES));
                    if (minute_next == 6'd0)
                    begin
                        hour_next = 5'(inc_wrap({2'b0, hour_reg}, HOURS));
                    end
                end
                updated = 1'b1;
            end

            if (do_apply)
            begin
                if (held_reg[BTN_UP])
                begin
                    if (held_reg[BTN_HOUR])
                        hour_next = 5'(inc_wrap({2'b0, hour_reg}, HOURS));
                    if (held_reg[BTN_MIN])
                        minute_next = 6'(inc_wrap({1'b0, minute_reg}, MINUTES));
                    if (held_reg[BTN_SEC])
                        second_next = 6'(inc_wrap({1'b0, second_reg}, MINUTES));
                    updated = 1'b1;
                end
                else if (held_reg[BTN_DOWN])
                begin
                    if (held_reg[BTN_HOUR])
                        hour_next = 5'(dec_wrap({2'b0, hour_reg}, HOURS));
                    if (held_reg[BTN_MIN])
                        minute_next = 6'(dec_wrap({1'b0, minute_reg}, MINUTES));
                    if (held_reg[BTN_SEC])
                        second_next = 6'(dec_wrap({1'b0, second_reg}, MINUTES));
                    updated = 1'b1;
                end
            end

            if (deb_fire && !held_reg[BTN_UP] && !held_reg[BTN_DOWN])
            begin
                pa_next = 1'b0;
            end
            else if (rep_fire || (deb_fire && any_held))
            begin
                pa_next = 1'b1;
            end

            if (rep_reg != 7'd0)
            begin
                rep_next = rep_fire ? cfg.repeat_period : (rep_reg - 7'd1);
            end
            if (deb_reg != 4'd0)
            begin
                deb_next = deb_reg - 4'd1;
            end
        end

        res.hour_now     = hour_next;
        res.minute_now   = minute_next;
        res.second_now   = second_next;
        res.time_updated = updated;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= '0;
            deb_reg      <= '0;
            rep_reg      <= '0;
            held_reg     <= '0;
            pa_reg       <= 1'b0;
            hour_reg     <= '0;
            minute_reg   <= '0;
            second_reg   <= '0;
        end
        else if (advance)
        begin
            prescale_reg <= prescale_next;
            deb_reg      <= deb_next;
            rep_reg      <= rep_next;
            held_reg     <= held_next;
            pa_reg       <= pa_next;
            hour_reg     <= hour_next;
            minute_reg   <= minute_next;
            second_reg   <= second_next;
        end
    end

    `HMS_ASSERT_SAME(a_time_range, 1'b1,
        (hour_reg < 5'd24) && (minute_reg < 6'd60) && (second_reg < 6'd60),
        "time register out of range")
    `HMS_ASSERT_SAME(a_event_quiet, advance && item.func, !res.time_updated,
        "button item reported a time update")
    `HMS_ASSERT_NEXT(a_debounce_reload, advance && item.func,
        deb_reg == $past(cfg.debounce_ticks), "debounce countdown not reloaded")
    `HMS_ASSERT_NEXT(a_second_moves,
        advance && !item.func && (held_reg == 5'd0) && res.time_updated,
        second_reg != $past(second_reg), "time update without second change")

endmodule

[hw/rtl/hms_out_stage.sv]
// Result register: holds one result until the downstream side takes it.
module hms_out_stage
    import hms_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    output logic    space,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign space    = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

[hw/rtl/hms_clock_with_button_setting.sv]
// 24-hour hours:minutes:seconds clock with push-button setting. Every item
// on the slave stream is a timer tick (tuser 0) or a new button state
// (tuser 1), and each yields exactly one result with the time after that item
// and a flag that is set when the time advanced or was adjusted. One item is
// taken per clock cycle while the master side keeps up; a result becomes valid
// on the master side after its item is accepted: the item sits in the input
// register while the single next-state step computes its result, which the
// result register captures when the core takes the item. Backpressure on the
// master side stalls the input once both registers are full. Write the
// configuration registers only while no item is in flight.
module hms_clock_with_button_setting
    import hms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [4:0] buttons, [7:5] zero
    input  logic [0:0]  s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [4:0] hour_now, [10:5] minute_now,
                                   // [16:11] second_now, [23:17] zero
    output logic [0:0]  m_tuser,   // [0] time_updated
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    cfg_t    cfg_reg;
    item_t   s_item;
    item_t   item;
    logic    in_valid;
    logic    space;
    logic    advance;
    result_t res;
    result_t m_res;

    assign s_item.func    = s_tuser[0];
    assign s_item.buttons = s_tdata[4:0];
    assign advance        = in_valid && space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_divide    <= TICK_DIVIDE_RST;
            cfg_reg.debounce_ticks <= DEBOUNCE_TICKS_RST;
            cfg_reg.repeat_delay   <= REPEAT_DELAY_RST;
            cfg_reg.repeat_period  <= REPEAT_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TICK_DIVIDE:    cfg_reg.tick_divide    <= cfg_data;
                CFG_DEBOUNCE_TICKS: cfg_reg.debounce_ticks <= cfg_data[3:0];
                CFG_REPEAT_DELAY:   cfg_reg.repeat_delay   <= cfg_data;
                CFG_REPEAT_PERIOD:  cfg_reg.repeat_period  <= cfg_data;
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    hms_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .take     (advance),
        .valid    (in_valid),
        .item     (item)
    );

    hms_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .cfg     (cfg_reg),
        .res     (res)
    );

    hms_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .res      (res),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = {7'd0, m_res.second_now, m_res.minute_now, m_res.hour_now};
    assign m_tuser = m_res.time_updated;

endmodule
